@@ sv/bte_pkg.sv @@
// ----------------------------------------------------------------------------
// bte_pkg
// Types, codes and the days-in-month helper for the BCD time/date editor.
// ----------------------------------------------------------------------------
package bte_pkg;

  typedef enum logic [2:0] {
    OP_DIGIT  = 3'd0,
    OP_FWD    = 3'd1,
    OP_BACK   = 3'd2,
    OP_OK     = 3'd3,
    OP_CANCEL = 3'd4,
    OP_OTHER  = 3'd5,
    OP_TIME   = 3'd6,
    OP_DATE   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_TIME = 2'd1,
    MODE_DATE = 2'd2
  } mode_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] digit;
  } key_t;

  typedef struct packed {
    logic [5:0] hour_bcd;
    logic [6:0] minute_bcd;
    logic [5:0] day_bcd;
    logic [4:0] month_bcd;
    logic [7:0] year_bcd;
    mode_t      edit_mode;
    logic [2:0] cursor;
    logic       committed;
    logic       wrong_key;
  } disp_t;

  localparam logic [5:0] HOUR_CLAMP  = 6'h23;
  localparam logic [4:0] MONTH_LAST  = 5'h12;
  localparam logic [5:0] DAYS_31     = 6'h31;
  localparam logic [5:0] DAYS_30     = 6'h30;
  localparam logic [5:0] DAYS_29     = 6'h29;
  localparam logic [5:0] DAYS_28     = 6'h28;
  localparam logic [5:0] DAY_FIRST   = 6'h01;
  localparam logic [4:0] MONTH_FIRST = 5'h01;
  localparam logic [7:0] YEAR_RESET  = 8'h24;

  localparam logic [2:0] TIME_LAST_POS = 3'd3;
  localparam logic [2:0] DATE_LAST_POS = 3'd5;

  // The decimal year 10*t + o is divisible by 4 exactly when 2*t + o is, so
  // only the low bits of the two digits matter.
  function automatic logic [5:0] bte_max_day(input logic [4:0] month,
                                             input logic [7:0] year);
    logic leap;
    leap = (year[0] == 1'b0) && (year[4] == year[1]);
    case (month)
      5'h04, 5'h06, 5'h09, 5'h11: bte_max_day = DAYS_30;
      5'h02:                      bte_max_day = leap ? DAYS_29 : DAYS_28;
      default:                    bte_max_day = DAYS_31;
    endcase
  endfunction

endpackage

@@ sv/bcd_time_date_entry_editor.sv @@
// ----------------------------------------------------------------------------
// bcd_time_date_entry_editor
// Keypad editor for a packed-BCD clock with committed and working copies.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake               Payload
//  key      in         key_valid / key_stall   key_t  (op, digit)
//  disp     out        disp_valid / disp_stall disp_t (shown values, flags)
//
//  One key request is taken every unstalled cycle; its result appears in the
//  output register the next cycle. The key state update and the digit checks
//  are a single pass of compare-and-select logic between the state registers
//  and the output register. A stalled result holds the output register, and
//  a new key is taken as soon as the waiting result leaves. Reset restores
//  the default time and date and idles the editor; no keys are taken during it.
// ----------------------------------------------------------------------------
module bcd_time_date_entry_editor (
  input  logic          clk,
  input  logic          rst,
  input  logic          key_valid,
  output logic          key_stall,
  input  bte_pkg::key_t key,
  output logic          disp_valid,
  input  logic          disp_stall,
  output bte_pkg::disp_t disp
);
  import bte_pkg::*;

  logic [5:0] saved_hour,   saved_hour_next;
  logic [6:0] saved_minute, saved_minute_next;
  logic [5:0] saved_day,    saved_day_next;
  logic [4:0] saved_month,  saved_month_next;
  logic [7:0] saved_year,   saved_year_next;
  logic [5:0] work_hour,    work_hour_next;
  logic [6:0] work_minute,  work_minute_next;
  logic [5:0] work_day,     work_day_next;
  logic [4:0] work_month,   work_month_next;
  logic [7:0] work_year,    work_year_next;
  mode_t      mode,         mode_next;
  logic [2:0] cursor_pos,   cursor_pos_next;
  logic       committed_next;
  logic       wrong_next;
  logic       accept;

  assign key_stall = rst | (disp_valid & disp_stall);
  assign accept    = key_valid & ~key_stall;

  always_comb begin
    logic [3:0] d;
    logic [2:0] last;
    logic [5:0] maxd_cur;
    logic [5:0] maxd_fix;
    d        = key.digit;
    last     = (mode == MODE_DATE) ? DATE_LAST_POS : TIME_LAST_POS;
    maxd_cur = bte_max_day(work_month, work_year);
    maxd_fix = DAYS_31;

    saved_hour_next   = saved_hour;
    saved_minute_next = saved_minute;
    saved_day_next    = saved_day;
    saved_month_next  = saved_month;
    saved_year_next   = saved_year;
    work_hour_next    = work_hour;
    work_minute_next  = work_minute;
    work_day_next     = work_day;
    work_month_next   = work_month;
    work_year_next    = work_year;
    mode_next         = mode;
    cursor_pos_next   = cursor_pos;
    committed_next    = 1'b0;
    wrong_next        = 1'b0;

    if (key.op == OP_TIME || key.op == OP_DATE) begin
      work_hour_next   = saved_hour;
      work_minute_next = saved_minute;
      work_day_next    = saved_day;
      work_month_next  = saved_month;
      work_year_next   = saved_year;
      mode_next        = (key.op == OP_TIME) ? MODE_TIME : MODE_DATE;
      cursor_pos_next  = 3'd0;
    end else if (mode != MODE_IDLE) begin
      unique case (key.op)
        OP_DIGIT: begin
          if (d > 4'd9) begin
            wrong_next = 1'b1;
          end else if (mode == MODE_TIME) begin
            case (cursor_pos)
              3'd0: begin
                if (d <= 4'd2) begin
                  work_hour_next  = {d[1:0], work_hour[3:0]};
                  cursor_pos_next = 3'd1;
                end
                // Moving the tens to 2 pulls an hour past 23 back to 23.
                if (work_hour_next[5:4] == 2'd2 && work_hour_next[3:0] > 4'd3) begin
                  work_hour_next = HOUR_CLAMP;
                end
              end
              3'd1: begin
                if (!(work_hour[5:4] == 2'd2 && d > 4'd3)) begin
                  work_hour_next  = {work_hour[5:4], d};
                  cursor_pos_next = 3'd2;
                end
              end
              3'd2: begin
                if (d <= 4'd5) begin
                  work_minute_next = {d[2:0], work_minute[3:0]};
                  cursor_pos_next  = 3'd3;
                end
              end
              3'd3: begin
                work_minute_next = {work_minute[6:4], d};
                cursor_pos_next  = 3'd0;
              end
              default: begin
              end
            endcase
          end else begin
            case (cursor_pos)
              3'd0: begin
                if (d <= {2'b00, maxd_cur[5:4]}) begin
                  work_day_next   = {d[1:0], work_day[3:0]};
                  cursor_pos_next = 3'd1;
                end
              end
              3'd1: begin
                if ({work_day[5:4], d} <= maxd_cur) begin
                  work_day_next   = {work_day[5:4], d};
                  cursor_pos_next = 3'd2;
                end
              end
              3'd2: begin
                if (d <= 4'd1) begin
                  work_month_next = {d[0], work_month[3:0]};
                  cursor_pos_next = 3'd3;
                end
              end
              3'd3: begin
                if ({work_month[4], d} <= MONTH_LAST) begin
                  work_month_next = {work_month[4], d};
                  cursor_pos_next = 3'd4;
                end
              end
              3'd4: begin
                work_year_next  = {d, work_year[3:0]};
                cursor_pos_next = 3'd5;
              end
              3'd5: begin
                work_year_next  = {work_year[7:4], d};
                cursor_pos_next = 3'd0;
              end
              default: begin
              end
            endcase
            // Keep the date legal after every date digit.
            if (work_day_next == 6'h00) work_day_next = DAY_FIRST;
            if (work_month_next == 5'h00) work_month_next = MONTH_FIRST;
            if (work_month_next > MONTH_LAST) work_month_next = MONTH_LAST;
            maxd_fix = bte_max_day(work_month_next, work_year_next);
            if (work_day_next > maxd_fix) work_day_next = maxd_fix;
          end
        end
        OP_FWD: begin
          cursor_pos_next = (cursor_pos >= last) ? 3'd0 : cursor_pos + 3'd1;
        end
        OP_BACK: begin
          cursor_pos_next = (cursor_pos == 3'd0 || cursor_pos > last) ? last
                                                                      : cursor_pos - 3'd1;
        end
        OP_OK: begin
          saved_hour_next   = work_hour;
          saved_minute_next = work_minute;
          saved_day_next    = work_day;
          saved_month_next  = work_month;
          saved_year_next   = work_year;
          committed_next    = 1'b1;
          mode_next         = MODE_IDLE;
          cursor_pos_next   = 3'd0;
        end
        OP_CANCEL: begin
          work_hour_next   = saved_hour;
          work_minute_next = saved_minute;
          work_day_next    = saved_day;
          work_month_next  = saved_month;
          work_year_next   = saved_year;
          mode_next        = MODE_IDLE;
          cursor_pos_next  = 3'd0;
        end
        OP_OTHER: begin
          wrong_next = 1'b1;
        end
        OP_TIME, OP_DATE: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      saved_hour   <= 6'h00;
      saved_minute <= 7'h00;
      saved_day    <= DAY_FIRST;
      saved_month  <= MONTH_FIRST;
      saved_year   <= YEAR_RESET;
      work_hour    <= 6'h00;
      work_minute  <= 7'h00;
      work_day     <= DAY_FIRST;
      work_month   <= MONTH_FIRST;
      work_year    <= YEAR_RESET;
      mode         <= MODE_IDLE;
      cursor_pos   <= 3'd0;
      disp_valid   <= 1'b0;
    end else begin
      if (accept) begin
        saved_hour   <= saved_hour_next;
        saved_minute <= saved_minute_next;
        saved_day    <= saved_day_next;
        saved_month  <= saved_month_next;
        saved_year   <= saved_year_next;
        work_hour    <= work_hour_next;
        work_minute  <= work_minute_next;
        work_day     <= work_day_next;
        work_month   <= work_month_next;
        work_year    <= work_year_next;
        mode         <= mode_next;
        cursor_pos   <= cursor_pos_next;
        disp_valid   <= 1'b1;
      end else if (!disp_stall) begin
        disp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      disp.hour_bcd   <= work_hour_next;
      disp.minute_bcd <= work_minute_next;
      disp.day_bcd    <= work_day_next;
      disp.month_bcd  <= work_month_next;
      disp.year_bcd   <= work_year_next;
      disp.edit_mode  <= mode_next;
      disp.cursor     <= cursor_pos_next;
      disp.committed  <= committed_next;
      disp.wrong_key  <= wrong_next;
    end
  end

endmodule

@@ sv/bte_checker.sv @@
// ----------------------------------------------------------------------------
// bte_checker
// Port-level checks for the BCD time/date editor, bound to its top level.
// ----------------------------------------------------------------------------
module bte_checker (
  input logic           clk,
  input logic           rst,
  input logic           key_valid,
  input logic           key_stall,
  input bte_pkg::key_t  key,
  input logic           disp_valid,
  input logic           disp_stall,
  input bte_pkg::disp_t disp
);
  import bte_pkg::*;

  // A stalled result stays in place until it is taken.
  a_disp_hold: assert property (@(posedge clk) disable iff (rst)
    disp_valid && disp_stall |=> disp_valid && $stable(disp))
    else $error("stalled result changed or dropped");

  // Keys are held back only while a finished result waits.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    key_stall == (disp_valid && disp_stall))
    else $error("key stall without a waiting result");

  // Every accepted key yields a result in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    key_valid && !key_stall |=> disp_valid)
    else $error("accepted key produced no result");

  // While idle the cursor rests at zero and no key is flagged.
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    disp_valid && disp.edit_mode == MODE_IDLE |-> disp.cursor == 3'd0 && !disp.wrong_key)
    else $error("idle result shows cursor or error flag");

  // A commit always ends the edit.
  a_commit_idle: assert property (@(posedge clk) disable iff (rst)
    disp_valid && disp.committed |-> disp.edit_mode == MODE_IDLE && !disp.wrong_key)
    else $error("commit left the editor in an edit mode");

endmodule

bind bcd_time_date_entry_editor bte_checker u_bte_checker (.*);
